// ===== design/sfsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfsd_pkg
// Types, constants and the CRC-16/Modbus byte update shared by the serial
// frame sync detector and its history cells.
// ----------------------------------------------------------------------------
package sfsd_pkg;

    localparam logic [7:0]  FUNC_READ     = 8'h03;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  SYNC_HEAD     = 8'h55;
    localparam logic [7:0]  SYNC_TYPE_MIN = 8'h50;
    localparam logic [7:0]  SYNC_TYPE_MAX = 8'h5C;
    localparam int          SYNC_LEN      = 11;
    localparam logic [7:0]  ADDR_RESET    = 8'd80;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic        reply_hit;
        logic        sync_hit;
        logic [15:0] reply_count;
        logic [15:0] sync_count;
    } t_out_item;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

// ===== design/sfsd_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfsd_cell
// One stage of the byte history: holds a byte, the CRC and the 8-bit sum
// of all bytes from the newest up to its own, and hands them on each item.
// ----------------------------------------------------------------------------
module sfsd_cell (
    input  wire         i_clk,
    input  wire         i_en,
    input  wire  [7:0]  i_cur_byte,
    input  wire  [7:0]  i_prev_byte,
    input  wire  [15:0] i_prev_crc,
    input  wire  [7:0]  i_prev_sum,
    output logic [7:0]  o_byte,
    output logic [15:0] o_crc,
    output logic [7:0]  o_sum
);
    import sfsd_pkg::*;

    logic [7:0]  r_byte;
    logic [15:0] r_crc;
    logic [7:0]  r_sum;
    logic [15:0] n_crc;
    logic [7:0]  n_sum;

    always_comb begin
        n_crc = crc_update(i_prev_crc, i_cur_byte);
        n_sum = i_prev_sum + i_cur_byte;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_byte <= i_prev_byte;
            r_crc  <= n_crc;
            r_sum  <= n_sum;
        end
    end

    assign o_byte = r_byte;
    assign o_crc  = r_crc;
    assign o_sum  = r_sum;

endmodule
`default_nettype wire

// ===== design/serial_frame_sync_detector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_sync_detector
// Takes one received byte per item and flags, at every offset, a Modbus
// read reply (address, 0x03, byte count, data, CRC-16/Modbus low byte first)
// and an 11-byte sync frame (0x55, type 0x50..0x5C, sum byte) ending at that
// byte, with saturating counts of each. One byte is accepted every cycle
// while results are taken; a result held by a stall holds off the next item.
// The result is registered in the output register in the cycle after acceptance.
// Each history cell does one CRC byte update per accepted byte; the reply
// check adds one more CRC byte update on the newest byte and tests for a
// zero residue.
// ----------------------------------------------------------------------------
module serial_frame_sync_detector #(
    parameter int REGISTER_COUNT = 15
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire  [7:0]           i_cfg_data,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire  sfsd_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output sfsd_pkg::t_out_item  o_out_item
);
    import sfsd_pkg::*;

    localparam int REPLY_LEN  = 2 * REGISTER_COUNT + 5;
    localparam int HIST_DEPTH = (REPLY_LEN - 1 > SYNC_LEN - 1) ? REPLY_LEN - 1 : SYNC_LEN - 1;
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
    localparam logic [7:0] BYTE_COUNT = 8'(2 * REGISTER_COUNT);

    logic [7:0]        r_dev_addr;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [15:0]       r_reply_total;
    logic [15:0]       r_sync_total;
    logic [15:0]       n_reply_total;
    logic [15:0]       n_sync_total;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              w_in_acc;
    logic              w_reply_hit;
    logic              w_sync_hit;
    logic [FILL_W-1:0] w_fill_base;
    logic [15:0]       w_reply_base;
    logic [15:0]       w_sync_base;
    logic [15:0]       w_residue;
    logic [7:0]        w_type;

    logic [7:0]  w_byte [HIST_DEPTH];
    logic [15:0] w_crc  [HIST_DEPTH];
    logic [7:0]  w_sum  [HIST_DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // history chain, cell k holds age k+1
    for (genvar g = 0; g < HIST_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            sfsd_cell u_cell (
                .i_clk       (i_clk),
                .i_en        (w_in_acc),
                .i_cur_byte  (i_in_item.rx_byte),
                .i_prev_byte (i_in_item.rx_byte),
                .i_prev_crc  (CRC_INIT),
                .i_prev_sum  (8'h00),
                .o_byte      (w_byte[g]),
                .o_crc       (w_crc[g]),
                .o_sum       (w_sum[g])
            );
        end else begin : g_body
            sfsd_cell u_cell (
                .i_clk       (i_clk),
                .i_en        (w_in_acc),
                .i_cur_byte  (i_in_item.rx_byte),
                .i_prev_byte (w_byte[g-1]),
                .i_prev_crc  (w_crc[g-1]),
                .i_prev_sum  (w_sum[g-1]),
                .o_byte      (w_byte[g]),
                .o_crc       (w_crc[g]),
                .o_sum       (w_sum[g])
            );
        end
    end

    always_comb begin
        w_fill_base  = i_in_item.restart ? '0 : r_fill;
        w_reply_base = i_in_item.restart ? 16'h0000 : r_reply_total;
        w_sync_base  = i_in_item.restart ? 16'h0000 : r_sync_total;

        // crc over the whole frame including its crc bytes leaves zero
        w_residue   = crc_update(w_crc[REPLY_LEN-2], i_in_item.rx_byte);
        w_reply_hit = (w_fill_base >= FILL_W'(REPLY_LEN - 1))
                   && (w_byte[REPLY_LEN-2] == r_dev_addr)
                   && (w_byte[REPLY_LEN-3] == FUNC_READ)
                   && (w_byte[REPLY_LEN-4] == BYTE_COUNT)
                   && (w_residue == 16'h0000);

        w_type     = w_byte[SYNC_LEN-3];
        w_sync_hit = (w_fill_base >= FILL_W'(SYNC_LEN - 1))
                  && (w_byte[SYNC_LEN-2] == SYNC_HEAD)
                  && (w_type >= SYNC_TYPE_MIN) && (w_type <= SYNC_TYPE_MAX)
                  && (w_sum[SYNC_LEN-2] == i_in_item.rx_byte);

        n_reply_total = (w_reply_hit && w_reply_base != COUNT_MAX)
                      ? w_reply_base + 16'd1 : w_reply_base;
        n_sync_total  = (w_sync_hit && w_sync_base != COUNT_MAX)
                      ? w_sync_base + 16'd1 : w_sync_base;
        n_fill        = (w_fill_base < FILL_W'(HIST_DEPTH))
                      ? w_fill_base + FILL_W'(1) : w_fill_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= ADDR_RESET;
            r_fill        <= '0;
            r_reply_total <= 16'h0000;
            r_sync_total  <= 16'h0000;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dev_addr <= i_cfg_data;
            end
            if (w_in_acc) begin
                r_fill        <= n_fill;
                r_reply_total <= n_reply_total;
                r_sync_total  <= n_sync_total;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_item.reply_hit   <= w_reply_hit;
            r_out_item.sync_hit    <= w_sync_hit;
            r_out_item.reply_count <= n_reply_total;
            r_out_item.sync_count  <= n_sync_total;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef ASSERT_OFF
    a_restart_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_item.restart |=> !o_out_item.reply_hit && !o_out_item.sync_hit)
        else $error("hit flagged on the item that restarts history");

    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.reply_hit |-> o_out_item.reply_count != 16'h0000)
        else $error("reply hit without a counted reply");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_out_item.reply_count == r_reply_total
                  && o_out_item.sync_count == r_sync_total)
        else $error("output counts differ from running totals");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(HIST_DEPTH))
        else $error("fill level beyond history depth");
`endif

endmodule
`default_nettype wire
